/* rtl/gmdfs_pkg.sv */
// gmdfs_pkg: shared types, codes and the control store for the grid maze search block
// used by gmdfs_useq, gmdfs_dpath and grid_maze_depth_first_search; no dependencies
package gmdfs_pkg;

	// default store geometry
	localparam int DEF_MAX_ROWS = 32;
	localparam int DEF_MAX_COLS = 32;

	// item and register field widths
	localparam int CMD_W   = 2;
	localparam int IDX_W   = 5;
	localparam int CODE_W  = 2;
	localparam int MARK_W  = 3;
	localparam int CFG_W   = 6;
	localparam int CFG_IDX_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;
	localparam logic [CFG_W-1:0]     GRID_RESET    = 6'd32;

	// commands
	localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RUN  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

	// cell codes held in the store
	localparam logic [MARK_W-1:0] CELL_OPEN      = 3'd0;
	localparam logic [MARK_W-1:0] CELL_WALL      = 3'd1;
	localparam logic [MARK_W-1:0] CELL_FINISH    = 3'd2;
	localparam logic [MARK_W-1:0] CELL_START     = 3'd3;
	localparam logic [MARK_W-1:0] CELL_EXPLORED  = 3'd4;
	localparam logic [MARK_W-1:0] CELL_HIT_OPEN  = 3'd5;
	localparam logic [MARK_W-1:0] CELL_HIT_START = 3'd6;

	// neighbour directions in search order
	localparam logic [1:0] DIR_LEFT  = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;
	localparam logic [1:0] DIR_UP    = 2'd3;

	// micro-operations of the datapath
	typedef enum logic [3:0] {
		OP_ACCEPT = 4'd0,
		OP_LOAD   = 4'd1,
		OP_READ   = 4'd2,
		OP_MARK   = 4'd3,
		OP_START  = 4'd4,
		OP_TRY    = 4'd5,
		OP_ENTER  = 4'd6,
		OP_SWEEP  = 4'd7,
		OP_EMIT   = 4'd8
	} op_t;

	// sequencing conditions
	typedef enum logic [2:0] {
		COND_NEXT       = 3'd0,
		COND_GOTO       = 3'd1,
		COND_DISPATCH   = 3'd2,
		COND_LOOP       = 3'd3,
		COND_HOLD_SWEEP = 3'd4,
		COND_WAIT_OUT   = 3'd5
	} cond_t;

	localparam int UPC_W = 4;
	typedef logic [UPC_W-1:0] upc_t;

	// step addresses of the control program
	localparam upc_t U_IDLE   = 4'd0;
	localparam upc_t U_LOAD   = 4'd1;
	localparam upc_t U_READ   = 4'd2;
	localparam upc_t U_MARK   = 4'd3;
	localparam upc_t U_RUN    = 4'd4;
	localparam upc_t U_TRY    = 4'd5;
	localparam upc_t U_ENTER  = 4'd6;
	localparam upc_t U_SWEEP  = 4'd7;
	localparam upc_t U_RESULT = 4'd8;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		upc_t  target;
	} uword_t;

	// sequencer to datapath
	typedef struct packed {
		op_t  op;
		logic cmd_ready;
	} ctrl_t;

	// datapath to sequencer
	typedef struct packed {
		logic done;
		logic sweep_end;
		logic out_free;
	} stat_t;

	// control store
	function automatic uword_t ucode(input upc_t addr);
		uword_t w;
		case (addr)
			U_IDLE:   w = '{op: OP_ACCEPT, cond: COND_DISPATCH,   target: U_IDLE};
			U_LOAD:   w = '{op: OP_LOAD,   cond: COND_GOTO,       target: U_RESULT};
			U_READ:   w = '{op: OP_READ,   cond: COND_NEXT,       target: U_IDLE};
			U_MARK:   w = '{op: OP_MARK,   cond: COND_GOTO,       target: U_RESULT};
			U_RUN:    w = '{op: OP_START,  cond: COND_GOTO,       target: U_ENTER};
			U_TRY:    w = '{op: OP_TRY,    cond: COND_NEXT,       target: U_IDLE};
			U_ENTER:  w = '{op: OP_ENTER,  cond: COND_LOOP,       target: U_TRY};
			U_SWEEP:  w = '{op: OP_SWEEP,  cond: COND_HOLD_SWEEP, target: U_IDLE};
			U_RESULT: w = '{op: OP_EMIT,   cond: COND_WAIT_OUT,   target: U_IDLE};
			default:  w = '{op: OP_ACCEPT, cond: COND_GOTO,       target: U_IDLE};
		endcase
		return w;
	endfunction

	// entry step for each command
	function automatic upc_t dispatch(input logic [CMD_W-1:0] cmd);
		upc_t t;
		case (cmd)
			CMD_LOAD: t = U_LOAD;
			CMD_RUN:  t = U_RUN;
			CMD_READ: t = U_READ;
			default:  t = U_RESULT;
		endcase
		return t;
	endfunction

endpackage

/* rtl/gmdfs_useq.sv */
// gmdfs_useq: step counter and control store of the grid maze search block
// depends on gmdfs_pkg (control word, conditions, program)
module gmdfs_useq import gmdfs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  logic [CMD_W-1:0] command,
	input  stat_t            stat,
	output ctrl_t            ctrl
);

	upc_t   upc_q;
	upc_t   upc_next;
	uword_t uw;

	// fetch and next step selection
	always_comb begin
		uw = ucode(upc_q);
		case (uw.cond)
			COND_NEXT:       upc_next = upc_q + upc_t'(1);
			COND_GOTO:       upc_next = uw.target;
			COND_DISPATCH:   upc_next = cmd_valid ? dispatch(command) : upc_q;
			COND_LOOP:       upc_next = stat.done ? upc_q + upc_t'(1) : uw.target;
			COND_HOLD_SWEEP: upc_next = stat.sweep_end ? upc_q + upc_t'(1) : upc_q;
			COND_WAIT_OUT:   upc_next = stat.out_free ? uw.target : upc_q;
			default:         upc_next = U_IDLE;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= U_IDLE;
		end else begin
			upc_q <= upc_next;
		end
	end

	assign ctrl.op        = uw.op;
	assign ctrl.cmd_ready = (uw.op == OP_ACCEPT);

endmodule

/* rtl/gmdfs_dpath.sv */
// gmdfs_dpath: cell store, path stack, search registers and result register
// depends on gmdfs_pkg; driven one micro-operation per cycle by gmdfs_useq
module gmdfs_dpath import gmdfs_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctrl_t                ctrl,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 cmd_valid,
	input  logic [CMD_W-1:0]     command,
	input  logic [IDX_W-1:0]     row_index,
	input  logic [IDX_W-1:0]     col_index,
	input  logic [CODE_W-1:0]    cell_code,
	input  logic                 rsp_stall,
	output logic                 rsp_valid,
	output logic                 finish_found,
	output logic [MARK_W-1:0]    cell_mark,
	output logic [CMD_W-1:0]     echo_command,
	output stat_t                stat
);

	localparam int RW     = $clog2(MAX_ROWS);
	localparam int CW     = $clog2(MAX_COLS);
	localparam int AW     = RW + CW;
	localparam int CDEPTH = 1 << AW;
	localparam int SDEPTH = MAX_ROWS * MAX_COLS;
	localparam int SAW    = $clog2(SDEPTH);
	localparam int SPW    = $clog2(SDEPTH + 1);
	localparam int SW     = RW + CW + 2;

	// configuration
	logic [CFG_W-1:0]  grid_rows_q, grid_cols_q;

	// latched item
	logic [CMD_W-1:0]  cmd_q;
	logic [IDX_W-1:0]  row_q, col_q;
	logic [CODE_W-1:0] code_q;

	// search state
	logic [RW-1:0]     start_row_q, cur_row_q, probe_row_q;
	logic [CW-1:0]     start_col_q, cur_col_q, probe_col_q;
	logic [1:0]        cur_dir_q;
	logic [SPW-1:0]    sp_q;
	logic              pop_q, probe_ok_q, found_q;
	logic [MARK_W-1:0] mark_q;
	logic [AW:0]       swc_q;
	logic              sw_v_q;
	logic [AW-1:0]     sw_wa_q;

	// result register
	logic              rsp_valid_q, found_out_q;
	logic [MARK_W-1:0] mark_out_q;
	logic [CMD_W-1:0]  echo_out_q;

	// memories
	logic [MARK_W-1:0] cell_mem [CDEPTH];
	logic [MARK_W-1:0] cell_rd_q;
	logic [SW-1:0]     stk_mem [SDEPTH];
	logic [SW-1:0]     stk_rd_q;

	logic              cell_we, cell_re, stk_we, stk_re;
	logic [AW-1:0]     cell_wa, cell_ra;
	logic [MARK_W-1:0] cell_wd;
	logic [SAW-1:0]    stk_wa, stk_ra;
	logic [SW-1:0]     stk_wd;

	logic [RW:0]       row_p1;
	logic [CW:0]       col_p1;
	logic [RW-1:0]     nb_row;
	logic [CW-1:0]     nb_col;
	logic              nb_ok, start_ok, item_in_store;
	logic [AW-1:0]     item_addr;
	logic              is_fin, can_enter, sp_empty, out_free, sweep_hit;
	logic [SW-1:0]     top_eff;
	logic [SPW-1:0]    sp_m1, sp_m2;

	// neighbour of the top cell in its current direction, walls outside the grid
	always_comb begin
		row_p1 = {1'b0, cur_row_q} + (RW+1)'(1);
		col_p1 = {1'b0, cur_col_q} + (CW+1)'(1);
		nb_row = cur_row_q;
		nb_col = cur_col_q;
		nb_ok  = 1'b0;
		case (cur_dir_q)
			DIR_LEFT: begin
				nb_col = cur_col_q - CW'(1);
				nb_ok  = (cur_col_q != '0);
			end
			DIR_DOWN: begin
				nb_row = row_p1[RW-1:0];
				nb_ok  = (32'(row_p1) < 32'(grid_rows_q)) && (32'(row_p1) < 32'(MAX_ROWS));
			end
			DIR_RIGHT: begin
				nb_col = col_p1[CW-1:0];
				nb_ok  = (32'(col_p1) < 32'(grid_cols_q)) && (32'(col_p1) < 32'(MAX_COLS));
			end
			DIR_UP: begin
				nb_row = cur_row_q - RW'(1);
				nb_ok  = (cur_row_q != '0);
			end
			default: begin
				nb_ok = 1'b0;
			end
		endcase
	end

	// address checks and entry decision
	always_comb begin
		start_ok = (32'(start_row_q) < 32'(grid_rows_q)) && (32'(start_row_q) < 32'(MAX_ROWS))
			&& (32'(start_col_q) < 32'(grid_cols_q)) && (32'(start_col_q) < 32'(MAX_COLS));
		item_in_store = (32'(row_q) < 32'(MAX_ROWS)) && (32'(col_q) < 32'(MAX_COLS));
		item_addr = {RW'(row_q), CW'(col_q)};
		is_fin    = probe_ok_q && (cell_rd_q == CELL_FINISH);
		can_enter = probe_ok_q && ((cell_rd_q == CELL_OPEN) || (cell_rd_q == CELL_EXPLORED)
			|| (cell_rd_q == CELL_START));
		top_eff   = pop_q ? stk_rd_q : {cur_row_q, cur_col_q, cur_dir_q};
		sp_empty  = (sp_q == '0);
		sp_m1     = sp_q - SPW'(1);
		sp_m2     = sp_q - SPW'(2);
		out_free  = !rsp_valid_q || !rsp_stall;
		sweep_hit = (cell_rd_q == CELL_HIT_OPEN) || (cell_rd_q == CELL_HIT_START);
	end

	assign stat.done      = is_fin || (!can_enter && sp_empty);
	assign stat.sweep_end = swc_q[AW];
	assign stat.out_free  = out_free;

	// memory port control
	always_comb begin
		cell_we = 1'b0;
		cell_wa = {probe_row_q, probe_col_q};
		cell_wd = CELL_HIT_OPEN;
		cell_re = 1'b0;
		cell_ra = item_addr;
		stk_we  = 1'b0;
		stk_wa  = sp_m1[SAW-1:0];
		stk_wd  = top_eff;
		stk_re  = 1'b0;
		stk_ra  = sp_m2[SAW-1:0];
		case (ctrl.op)
			OP_LOAD: begin
				cell_we = item_in_store;
				cell_wa = item_addr;
				cell_wd = {1'b0, code_q};
			end
			OP_READ: begin
				cell_re = 1'b1;
			end
			OP_START: begin
				cell_re = 1'b1;
				cell_ra = {start_row_q, start_col_q};
			end
			OP_TRY: begin
				cell_re = 1'b1;
				cell_ra = {nb_row, nb_col};
				stk_re  = (cur_dir_q == DIR_UP) && (sp_q > SPW'(1));
			end
			OP_ENTER: begin
				cell_we = can_enter;
				cell_wd = (cell_rd_q == CELL_START) ? CELL_HIT_START : CELL_HIT_OPEN;
				stk_we  = can_enter && !sp_empty;
			end
			OP_SWEEP: begin
				cell_re = !swc_q[AW];
				cell_ra = swc_q[AW-1:0];
				cell_we = sw_v_q && sweep_hit;
				cell_wa = sw_wa_q;
				cell_wd = (cell_rd_q == CELL_HIT_START) ? CELL_START : CELL_EXPLORED;
			end
			default: begin
				cell_we = 1'b0;
			end
		endcase
	end

	// cell store
	always_ff @(posedge clk) begin
		if (cell_we) begin
			cell_mem[cell_wa] <= cell_wd;
		end
		if (cell_re) begin
			cell_rd_q <= cell_mem[cell_ra];
		end
	end

	// path stack below the top entry
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_wa] <= stk_wd;
		end
		if (stk_re) begin
			stk_rd_q <= stk_mem[stk_ra];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= GRID_RESET;
			grid_cols_q <= GRID_RESET;
			start_row_q <= '0;
			start_col_q <= '0;
			sp_q        <= '0;
			pop_q       <= 1'b0;
			probe_ok_q  <= 1'b0;
			found_q     <= 1'b0;
			mark_q      <= CELL_OPEN;
			swc_q       <= '0;
			sw_v_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_GRID_ROWS: grid_rows_q <= cfg_wdata;
					REG_GRID_COLS: grid_cols_q <= cfg_wdata;
					default: ;
				endcase
			end
			// result register empties on its transfer unless a new result is loaded
			if (rsp_valid_q && !rsp_stall && (ctrl.op != OP_EMIT)) begin
				rsp_valid_q <= 1'b0;
			end
			case (ctrl.op)
				OP_ACCEPT: begin
					if (cmd_valid) begin
						found_q <= 1'b0;
						mark_q  <= CELL_OPEN;
					end
				end
				OP_LOAD: begin
					if (item_in_store && ({1'b0, code_q} == CELL_START)) begin
						start_row_q <= RW'(row_q);
						start_col_q <= CW'(col_q);
					end
				end
				OP_MARK: begin
					mark_q <= item_in_store ? cell_rd_q : CELL_WALL;
				end
				OP_START: begin
					sp_q       <= '0;
					pop_q      <= 1'b0;
					probe_ok_q <= start_ok;
					found_q    <= 1'b0;
					swc_q      <= '0;
					sw_v_q     <= 1'b0;
				end
				OP_TRY: begin
					probe_ok_q <= nb_ok;
					pop_q      <= (cur_dir_q == DIR_UP);
					if (cur_dir_q == DIR_UP) begin
						sp_q <= sp_m1;
					end
				end
				OP_ENTER: begin
					pop_q <= 1'b0;
					if (is_fin) begin
						found_q <= 1'b1;
					end
					if (can_enter) begin
						sp_q <= sp_q + SPW'(1);
					end
				end
				OP_SWEEP: begin
					sw_v_q <= !swc_q[AW];
					if (!swc_q[AW]) begin
						swc_q <= swc_q + (AW+1)'(1);
					end
				end
				OP_EMIT: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_ACCEPT: begin
				if (cmd_valid) begin
					cmd_q  <= command;
					row_q  <= row_index;
					col_q  <= col_index;
					code_q <= cell_code;
				end
			end
			OP_START: begin
				probe_row_q <= start_row_q;
				probe_col_q <= start_col_q;
			end
			OP_TRY: begin
				probe_row_q <= nb_row;
				probe_col_q <= nb_col;
				if (cur_dir_q != DIR_UP) begin
					cur_dir_q <= cur_dir_q + 2'd1;
				end
			end
			OP_ENTER: begin
				// a new cell becomes the top, else the top is reloaded after a pop
				if (can_enter) begin
					cur_row_q <= probe_row_q;
					cur_col_q <= probe_col_q;
					cur_dir_q <= DIR_LEFT;
				end else if (pop_q && !sp_empty) begin
					cur_row_q <= stk_rd_q[CW+2 +: RW];
					cur_col_q <= stk_rd_q[2 +: CW];
					cur_dir_q <= stk_rd_q[1:0];
				end
			end
			OP_SWEEP: begin
				sw_wa_q <= swc_q[AW-1:0];
			end
			OP_EMIT: begin
				if (out_free) begin
					found_out_q <= found_q;
					mark_out_q  <= mark_q;
					echo_out_q  <= cmd_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid    = rsp_valid_q;
	assign finish_found = found_out_q;
	assign cell_mark    = mark_out_q;
	assign echo_command = echo_out_q;

endmodule

/* rtl/grid_maze_depth_first_search.sv */
// grid_maze_depth_first_search: top level of the grid maze depth-first search block
// depends on gmdfs_pkg, gmdfs_useq (control program) and gmdfs_dpath (stores and datapath)

// The block holds a grid of MAX_ROWS x MAX_COLS cells and answers three commands, one
// result per command: load writes a cell code, read returns a cell mark (wall beyond the
// store), run does a depth-first search from the last loaded start cell, trying left,
// down, right, up, and reports whether a finish was reached; open cells it entered read
// as explored afterwards and start cells it entered keep their start code. A small
// control program steps a single datapath with one read and one write port on the cell
// store, so one command is worked on at a time. A command code of 3 also gets a result.
// Each result may wait for the result register. A run ends with a pass over the whole
// store that turns the visited cells back into explored or start marks. The user must
// write grid sizes only while no command is in flight; the block does not enforce it.
module grid_maze_depth_first_search import gmdfs_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  logic [CMD_W-1:0]     command,
	input  logic [IDX_W-1:0]     row_index,
	input  logic [IDX_W-1:0]     col_index,
	input  logic [CODE_W-1:0]    cell_code,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic                 finish_found,
	output logic [MARK_W-1:0]    cell_mark,
	output logic [CMD_W-1:0]     echo_command
);

	ctrl_t ctrl;
	stat_t stat;

	// control program
	gmdfs_useq u_useq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.command   (command),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	// stores and search datapath
	gmdfs_dpath #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.cmd_valid    (cmd_valid),
		.command      (command),
		.row_index    (row_index),
		.col_index    (col_index),
		.cell_code    (cell_code),
		.rsp_stall    (rsp_stall),
		.rsp_valid    (rsp_valid),
		.finish_found (finish_found),
		.cell_mark    (cell_mark),
		.echo_command (echo_command),
		.stat         (stat)
	);

	// a command is taken only at the idle step
	assign cmd_stall = !ctrl.cmd_ready;

`ifndef SYNTH
	// one command at a time: a transfer always leaves the block busy next cycle
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> cmd_stall)
		else $error("command taken while previous one still in flight");

	// only a run can report a finish
	a_found_only_run: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (echo_command != CMD_RUN)) |-> !finish_found)
		else $error("finish flag set on a non-run result");

	// only a read returns a cell mark
	a_mark_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (echo_command != CMD_READ)) |-> (cell_mark == CELL_OPEN))
		else $error("cell mark set on a non-read result");
`endif

endmodule

/* tb/grid_maze_depth_first_search_tb.sv */
// grid_maze_depth_first_search_tb: self-checking testbench for the grid maze search block
// drives load, run and read commands with random gaps and stalls and checks every result
// against a maze tracker that repeats the search; depends on gmdfs_pkg and the block rtl
module grid_maze_depth_first_search_tb import gmdfs_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_CELLS      = DEF_MAX_ROWS * DEF_MAX_COLS;
	localparam int MAX_WAIT       = 17;
	localparam int RANDOM_ITEMS   = 340;
	// side of the loaded block; a wall row and column just past it keep every walk inside
	localparam int FILL_SIDE      = 16;
	// a full 32 x 32 walk plus the marking pass stays well under this
	localparam int WATCHDOG_LIMIT = 40000;

	typedef struct packed {
		logic              found;
		logic [MARK_W-1:0] mark;
		logic [CMD_W-1:0]  cmd;
	} answer_t;

	// maze copy, search predictor and the answers still awaited
	class maze_tracker;
		logic [MARK_W-1:0] cells [NUM_CELLS];
		int                trail [NUM_CELLS];
		int                depth;
		int                start_idx;
		int                rows_in_use;
		int                cols_in_use;
		answer_t           awaited_answers[$];
		int                failures;

		function new();
			foreach (cells[i]) cells[i] = CELL_OPEN;
			depth       = 0;
			start_idx   = 0;
			rows_in_use = DEF_MAX_ROWS;
			cols_in_use = DEF_MAX_COLS;
			failures    = 0;
		endfunction

		function void set_grid(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
			rows_in_use = (int'(rows) > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(rows);
			cols_in_use = (int'(cols) > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(cols);
		endfunction

		function int pending();
			return awaited_answers.size();
		endfunction

		// 0 blocked, 1 entered and pushed, 2 finish reached
		function int try_enter(int r, int c);
			int idx;
			if (r < 0 || c < 0 || r >= rows_in_use || c >= cols_in_use)
				return 0;
			idx = r * DEF_MAX_COLS + c;
			case (cells[idx])
				CELL_FINISH: return 2;
				CELL_OPEN, CELL_EXPLORED: cells[idx] = CELL_HIT_OPEN;
				CELL_START: cells[idx] = CELL_HIT_START;
				default: return 0;
			endcase
			if (depth < NUM_CELLS) begin
				trail[depth] = idx * 4;
				depth++;
			end
			return 1;
		endfunction

		// depth-first walk trying left, down, right, up, then the marking pass
		function logic search_maze();
			int   res;
			int   top;
			int   idx;
			int   dir;
			int   r;
			int   c;
			logic found;
			found = 1'b0;
			depth = 0;
			res = try_enter(start_idx / DEF_MAX_COLS, start_idx % DEF_MAX_COLS);
			if (res == 2)
				found = 1'b1;
			while (!found && depth > 0) begin
				top = trail[depth - 1];
				idx = top / 4;
				dir = top % 4;
				r   = idx / DEF_MAX_COLS;
				c   = idx % DEF_MAX_COLS;
				if (dir == DIR_UP)
					depth--;
				else
					trail[depth - 1] = top + 1;
				if (dir == DIR_LEFT)
					res = try_enter(r, c - 1);
				else if (dir == DIR_DOWN)
					res = try_enter(r + 1, c);
				else if (dir == DIR_RIGHT)
					res = try_enter(r, c + 1);
				else
					res = try_enter(r - 1, c);
				if (res == 2)
					found = 1'b1;
			end
			depth = 0;
			foreach (cells[i]) begin
				if (cells[i] == CELL_HIT_OPEN)
					cells[i] = CELL_EXPLORED;
				else if (cells[i] == CELL_HIT_START)
					cells[i] = CELL_START;
			end
			return found;
		endfunction

		// accepted command transfer: update the maze and queue the answer
		function void note_command(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] r,
			logic [IDX_W-1:0] c, logic [CODE_W-1:0] code);
			answer_t want;
			int      idx;
			logic    in_store;
			want     = '{found: 1'b0, mark: CELL_OPEN, cmd: cmd};
			idx      = int'(r) * DEF_MAX_COLS + int'(c);
			in_store = int'(r) < DEF_MAX_ROWS && int'(c) < DEF_MAX_COLS;
			case (cmd)
				CMD_LOAD: begin
					if (in_store) begin
						cells[idx] = MARK_W'(code);
						if (MARK_W'(code) == CELL_START)
							start_idx = idx;
					end
				end
				CMD_RUN: want.found = search_maze();
				CMD_READ: want.mark = in_store ? cells[idx] : CELL_WALL;
				default: ;
			endcase
			awaited_answers.push_back(want);
		endfunction

		// accepted result transfer: compare with the oldest awaited answer
		function void check_answer(logic found, logic [MARK_W-1:0] mark,
			logic [CMD_W-1:0] cmd);
			answer_t want;
			if (awaited_answers.size() == 0) begin
				$display("%0t: unexpected result: finish_found %0d cell_mark %0d echo_command %0d",
					$time, found, mark, cmd);
				failures++;
				return;
			end
			want = awaited_answers.pop_front();
			if (found !== want.found) begin
				$display("%0t: finish_found expected %0d actual %0d", $time, want.found, found);
				failures++;
			end
			if (mark !== want.mark) begin
				$display("%0t: cell_mark expected %0d actual %0d", $time, want.mark, mark);
				failures++;
			end
			if (cmd !== want.cmd) begin
				$display("%0t: echo_command expected %0d actual %0d", $time, want.cmd, cmd);
				failures++;
			end
		endfunction
	endclass

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               cfg_wen      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index  = REG_GRID_ROWS;
	logic [CFG_W-1:0]   cfg_wdata    = '0;
	logic               cmd_valid    = 1'b0;
	logic               cmd_stall;
	logic [CMD_W-1:0]   command      = CMD_LOAD;
	logic [IDX_W-1:0]   row_index    = '0;
	logic [IDX_W-1:0]   col_index    = '0;
	logic [CODE_W-1:0]  cell_code    = '0;
	logic               rsp_valid;
	logic               rsp_stall    = 1'b0;
	logic               finish_found;
	logic [MARK_W-1:0]  cell_mark;
	logic [CMD_W-1:0]   echo_command;

	maze_tracker tracker;
	int          send_gap_max = MAX_WAIT;
	int          stall_max    = MAX_WAIT;
	int          random_items = 0;
	int          idle_cycles  = 0;

	grid_maze_depth_first_search i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.command      (command),
		.row_index    (row_index),
		.col_index    (col_index),
		.cell_code    (cell_code),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.finish_found (finish_found),
		.cell_mark    (cell_mark),
		.echo_command (echo_command)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// at least half the draws give no wait at all
	function automatic int draw_gap(int max_wait);
		if (max_wait == 0 || $urandom_range(1) == 0)
			return 0;
		return $urandom_range(max_wait);
	endfunction

	function automatic logic [CODE_W-1:0] pick_code();
		int roll;
		roll = $urandom_range(9);
		if (roll < 5)
			return CODE_W'(CELL_OPEN);
		if (roll < 8)
			return CODE_W'(CELL_WALL);
		if (roll == 8)
			return CODE_W'(CELL_FINISH);
		return CODE_W'(CELL_START);
	endfunction

	// mostly small grids, a few full, empty and oversized ones
	function automatic logic [CFG_W-1:0] pick_size();
		case ($urandom_range(19))
			0: return '0;
			1: return CFG_W'($urandom_range(63, 33));
			2, 3: return GRID_RESET;
			4, 5: return CFG_W'($urandom_range(31, 9));
			default: return CFG_W'($urandom_range(8, 1));
		endcase
	endfunction

	// position inside the grid in use and the loaded block, anywhere in the block when empty
	function automatic logic [IDX_W-1:0] pick_pos(logic [CFG_W-1:0] size);
		int used;
		used = (int'(size) > FILL_SIDE) ? FILL_SIDE : int'(size);
		if (used == 0)
			return IDX_W'($urandom_range(FILL_SIDE - 1));
		return IDX_W'($urandom_range(used - 1));
	endfunction

	// one command transfer after a random gap
	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] r,
		input logic [IDX_W-1:0] c, input logic [CODE_W-1:0] code);
		int gap;
		gap = draw_gap(send_gap_max);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		command   <= cmd;
		row_index <= r;
		col_index <= c;
		cell_code <= code;
		do @(posedge clk); while (cmd_stall);
		tracker.note_command(cmd, r, c, code);
	endtask

	// random-part command, sometimes preceded by a stray command
	task automatic send_random(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] r,
		input logic [IDX_W-1:0] c, input logic [CODE_W-1:0] code);
		logic [CMD_W-1:0] stray;
		if ($urandom_range(7) == 0) begin
			stray = CMD_W'($urandom_range(3));
			send_command(stray, IDX_W'($urandom_range(FILL_SIDE - 1)),
				IDX_W'($urandom_range(FILL_SIDE - 1)), CODE_W'($urandom_range(3)));
			if (stray != CMD_NONE)
				random_items++;
		end
		send_command(cmd, r, c, code);
		random_items++;
	endtask

	// hold off the sender until every awaited result is in
	task automatic drain_results();
		cmd_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_grid_size(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
		drain_results();
		cfg_wen   <= 1'b1;
		cfg_index <= REG_GRID_ROWS;
		cfg_wdata <= rows;
		@(posedge clk);
		cfg_index <= REG_GRID_COLS;
		cfg_wdata <= cols;
		@(posedge clk);
		cfg_wen <= 1'b0;
		tracker.set_grid(rows, cols);
	endtask

	// result side: random stall before each result transfer
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			hold = draw_gap(stall_max);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
			tracker.check_answer(finish_found, cell_mark, echo_command);
		end
	end

	// command side
	initial begin
		logic [CFG_W-1:0] rows_sz;
		logic [CFG_W-1:0] cols_sz;
		int               rounds;
		tracker = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// block of cells closed by a wall row and column, so no read or walk
		// touches an unwritten cell
		write_grid_size(GRID_RESET, GRID_RESET);
		for (int r = 0; r <= FILL_SIDE; r++)
			for (int c = 0; c <= FILL_SIDE; c++)
				send_command(CMD_LOAD, IDX_W'(r), IDX_W'(c),
					(r == FILL_SIDE || c == FILL_SIDE) ? CODE_W'(CELL_WALL) : pick_code());

		// full grid: corner start and finish, repeated run, idle command
		send_command(CMD_LOAD, 5'd0, 5'd0, CODE_W'(CELL_START));
		send_command(CMD_LOAD, 5'd31, 5'd31, CODE_W'(CELL_FINISH));
		send_command(CMD_RUN, 5'd0, 5'd0, 2'd0);
		send_command(CMD_READ, 5'd0, 5'd0, 2'd0);
		send_command(CMD_READ, 5'd31, 5'd31, 2'd3);
		send_command(CMD_READ, 5'd0, 5'd1, 2'd0);
		send_command(CMD_RUN, 5'd31, 5'd31, 2'd3);
		send_command(CMD_NONE, 5'd31, 5'd31, 2'd3);
		// new start leaves the old start-coded cell in the maze
		send_command(CMD_LOAD, 5'd31, 5'd0, CODE_W'(CELL_START));
		// start cell overwritten by a wall, then by a finish
		send_command(CMD_LOAD, 5'd31, 5'd0, CODE_W'(CELL_WALL));
		send_command(CMD_RUN, 5'd0, 5'd0, 2'd0);
		send_command(CMD_LOAD, 5'd31, 5'd0, CODE_W'(CELL_FINISH));
		send_command(CMD_RUN, 5'd0, 5'd0, 2'd0);
		send_command(CMD_LOAD, 5'd0, 5'd31, CODE_W'(CELL_START));

		// start outside a 4 x 4 grid, access to a cell outside the grid
		write_grid_size(6'd4, 6'd4);
		send_command(CMD_RUN, 5'd0, 5'd0, 2'd0);
		send_command(CMD_LOAD, 5'd20, 5'd20, CODE_W'(CELL_OPEN));
		send_command(CMD_READ, 5'd20, 5'd20, 2'd0);

		// single-cell grid
		write_grid_size(6'd1, 6'd1);
		send_command(CMD_LOAD, 5'd0, 5'd0, CODE_W'(CELL_START));
		send_command(CMD_RUN, 5'd0, 5'd0, 2'd0);
		send_command(CMD_READ, 5'd0, 5'd0, 2'd0);

		// empty grid
		write_grid_size(6'd0, 6'd63);
		send_command(CMD_RUN, 5'd0, 5'd0, 2'd0);

		// oversized values act as the full grid
		write_grid_size(6'd63, 6'd63);
		send_command(CMD_LOAD, 5'd5, 5'd5, CODE_W'(CELL_START));
		send_command(CMD_RUN, 5'd0, 5'd0, 2'd0);

		// random phases: build a small maze, run, read back, with stray commands
		while (random_items < RANDOM_ITEMS) begin
			rows_sz       = pick_size();
			cols_sz       = pick_size();
			send_gap_max  = ($urandom_range(3) == 0) ? 0 : MAX_WAIT;
			stall_max     = ($urandom_range(3) == 0) ? 0 : MAX_WAIT;
			write_grid_size(rows_sz, cols_sz);
			rounds = $urandom_range(6, 2);
			repeat (rounds) begin
				repeat ($urandom_range(8, 1))
					send_random(CMD_LOAD, pick_pos(rows_sz), pick_pos(cols_sz), pick_code());
				if ($urandom_range(4) < 2)
					send_random(CMD_LOAD, pick_pos(rows_sz), pick_pos(cols_sz),
						CODE_W'(CELL_START));
				if ($urandom_range(4) != 0)
					send_random(CMD_RUN, IDX_W'($urandom_range(31)),
						IDX_W'($urandom_range(31)), CODE_W'($urandom_range(3)));
				repeat ($urandom_range(4, 1))
					send_random(CMD_READ, pick_pos(rows_sz), pick_pos(cols_sz),
						CODE_W'($urandom_range(3)));
			end
		end

		drain_results();
		repeat (16) @(posedge clk);
		if (tracker.failures == 0 && tracker.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* files.f */
rtl/gmdfs_pkg.sv
rtl/gmdfs_useq.sv
rtl/gmdfs_dpath.sv
rtl/grid_maze_depth_first_search.sv
tb/grid_maze_depth_first_search_tb.sv
